// File: hw/rtl/pnt_pkg.sv
// ----------------------------------------------------------------------------
// pnt_pkg
// shared widths, state codes and divider status for the perfect number test
// ----------------------------------------------------------------------------
`default_nettype none

package pnt_pkg;

    localparam int VALUE_BITS = 31;
    localparam int SUM_W      = 34;
    localparam int ACC_W      = VALUE_BITS + 4;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'({SUM_W{1'b1}});

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_DIV_START = 6'b000010,
        ST_DIV_WAIT  = 6'b000100,
        ST_ADD_D     = 6'b001000,
        ST_ADD_Q     = 6'b010000,
        ST_FINISH    = 6'b100000
    } pnt_state_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic                  rem_zero;
    } pnt_div_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/pnt_div.sv
// ----------------------------------------------------------------------------
// pnt_div
// restoring divider, one quotient bit per cycle, shared by every trial divisor
// ----------------------------------------------------------------------------
`default_nettype none

module pnt_div
    import pnt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [VALUE_BITS-1:0] divisor,
    output pnt_div_res_t               res
);

    logic [VALUE_BITS-1:0] rem_reg,  rem_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   trial;

    always_comb begin
        trial     = {rem_reg, quot_reg[VALUE_BITS-1]} - {1'b0, divisor};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[VALUE_BITS]) begin
                rem_next = {rem_reg[VALUE_BITS-2:0], quot_reg[VALUE_BITS-1]};
            end else begin
                rem_next = trial[VALUE_BITS-1:0];
            end
            quot_next = {quot_reg[VALUE_BITS-2:0], ~trial[VALUE_BITS]};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign res.done     = done_reg;
    assign res.quot     = quot_reg;
    assign res.rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

// File: hw/rtl/perfect_number_test.sv
// sequence: inputs 0 and 1 go straight to the finish state, otherwise one division
// per trial divisor d = 2 .. floor(sqrt(n)) + 1, plus an add step for each divisor found
// and one for its cofactor when the two differ
// throughput: one word at a time, set by the bit-serial divider shared by all trials
// reset: synchronous active-low aresetn returns the sequencer to idle and drops m_valid
// ----------------------------------------------------------------------------
// perfect_number_test
// aliquot sum by trial division and perfect number flag
// ----------------------------------------------------------------------------
`default_nettype none

module perfect_number_test
    import pnt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VALUE_BITS-1:0] s_candidate,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_perfect_flag,
    output logic [SUM_W-1:0]           m_divisor_sum
);

    pnt_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg,     n_next;
    logic [VALUE_BITS-1:0] d_reg,     d_next;
    logic [VALUE_BITS-1:0] q_reg,     q_next;
    logic [ACC_W-1:0]      acc_reg,   acc_next;
    logic                  big_reg,   big_next;
    logic                  mv_reg,    mv_next;
    logic                  flag_reg,  flag_next;
    logic [SUM_W-1:0]      sum_reg,   sum_next;
    logic                  div_start;
    pnt_div_res_t          div_res;

    pnt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .res      (div_res)
    );

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        big_next   = big_reg;
        mv_next    = mv_reg;
        flag_next  = flag_reg;
        sum_next   = sum_reg;
        div_start  = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next   = s_candidate;
                    d_next   = VALUE_BITS'(2);
                    big_next = (s_candidate > VALUE_BITS'(1));
                    if (s_candidate > VALUE_BITS'(1)) begin
                        acc_next   = ACC_W'(1);
                        state_next = ST_DIV_START;
                    end else begin
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    q_next = div_res.quot;
                    if (d_reg > div_res.quot) begin
                        state_next = ST_FINISH;
                    end else if (div_res.rem_zero) begin
                        state_next = ST_ADD_D;
                    end else begin
                        d_next     = d_reg + VALUE_BITS'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_ADD_D: begin
                acc_next = acc_reg + ACC_W'(d_reg);
                if (q_reg != d_reg) begin
                    state_next = ST_ADD_Q;
                end else begin
                    d_next     = d_reg + VALUE_BITS'(1);
                    state_next = ST_DIV_START;
                end
            end
            ST_ADD_Q: begin
                acc_next   = acc_reg + ACC_W'(q_reg);
                d_next     = d_reg + VALUE_BITS'(1);
                state_next = ST_DIV_START;
            end
            ST_FINISH: begin
                // load the output word once the previous one has left
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    flag_next  = big_reg && (acc_reg == ACC_W'(n_reg));
                    sum_next   = (acc_reg > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(acc_reg);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        n_reg    <= n_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        big_reg  <= big_next;
        flag_reg <= flag_next;
        sum_reg  <= sum_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = mv_reg;
    assign m_perfect_flag = flag_reg;
    assign m_divisor_sum  = sum_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pnt_checker.sv
// ----------------------------------------------------------------------------
// pnt_checker
// port-level checks on the perfect number test, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pnt_checker
    import pnt_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_perfect_flag,
    input wire logic [SUM_W-1:0]      m_divisor_sum
);

    // one word in flight: the input side closes after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word was in flight");

    // a new result only appears at the end of a computation
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a finished computation");

    // a stalled result word holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_divisor_sum)
            && $stable(m_perfect_flag))
        else $error("result word changed while stalled");

    // a perfect number has a non-zero divisor sum
    a_flag_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_perfect_flag |-> m_divisor_sum != '0)
        else $error("perfect flag with zero divisor sum");

endmodule

bind perfect_number_test pnt_checker u_pnt_checker (.*);

`default_nettype wire

// File: tb/sv/perfect_number_test_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perfect_number_test_test
// Checks the aliquot sum and the perfect flag for every candidate word.
// A queue-fed driver offers candidates and an in-line trial-division
// predictor computes the expected sum and flag. A monitor compares every
// result word in order. The run goes through phases with and without
// sender gaps and receiver stalls, and includes one long receiver hold-off.
// ----------------------------------------------------------------------------

module perfect_number_test_test
    import pnt_pkg::*;
();

    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [VALUE_BITS-1:0] cand;
        logic                  flag;
        logic [SUM_W-1:0]      sum;
    } sum_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_candidate = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_perfect_flag;
    logic [SUM_W-1:0]      m_divisor_sum;

    logic [VALUE_BITS-1:0] cand_q [$];
    sum_result_t           sum_q [$];

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    bit                    hold_req = 1'b0;
    int                    hold_left = 0;
    int                    errors = 0;
    int                    words_sent = 0;
    int                    results_seen = 0;
    int                    perfect_seen = 0;
    int                    held_cycles = 0;
    logic [VALUE_BITS-1:0] largest_sent = '0;

    perfect_number_test u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_candidate    (s_candidate),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_perfect_flag (m_perfect_flag),
        .m_divisor_sum  (m_divisor_sum)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic sum_result_t aliquot_predict(input logic [VALUE_BITS-1:0] cand);
        longint unsigned n;
        longint unsigned acc;
        longint unsigned d;
        longint unsigned q;
        longint unsigned sum_cap;
        sum_result_t     r;
        n = 64'(cand);
        acc = 0;
        sum_cap = (64'd1 << SUM_W) - 64'd1;
        if (n > 1) begin
            acc = 1;
            for (d = 2; d <= n / d; d++) begin
                if (n % d == 0) begin
                    q = n / d;
                    acc += d;
                    if (q != d) begin
                        acc += q;
                    end
                end
            end
        end
        r.cand = cand;
        r.flag = (n > 1) && (acc == n);
        r.sum  = (acc > sum_cap) ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_candidate();
        int          bits;
        logic [31:0] mask;
        bits = $urandom_range(18, 1);
        mask = (32'd1 << bits) - 32'd1;
        return VALUE_BITS'($urandom & mask);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sum_q.push_back(aliquot_predict(s_candidate));
                words_sent++;
                if (s_candidate > largest_sent) begin
                    largest_sent = s_candidate;
                end
            end
            if (!s_valid || s_ready) begin
                if (cand_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid     <= 1'b1;
                    s_candidate <= cand_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            held_cycles <= held_cycles + 1;
        end
    end

    // monitor
    always @(posedge aclk) begin : mon
        sum_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (sum_q.size() == 0) begin
                    errors++;
                    $display("%0t: result word with nothing expected, flag %0b sum %0d",
                             $time, m_perfect_flag, m_divisor_sum);
                end else begin
                    want = sum_q.pop_front();
                    results_seen++;
                    if (m_perfect_flag) begin
                        perfect_seen++;
                    end
                    if (m_perfect_flag !== want.flag) begin
                        errors++;
                        $display("%0t: candidate %0d perfect_flag expected %0b actual %0b",
                                 $time, want.cand, want.flag, m_perfect_flag);
                    end
                    if (m_divisor_sum !== want.sum) begin
                        errors++;
                        $display("%0t: candidate %0d divisor_sum expected %0d actual %0d",
                                 $time, want.cand, want.sum, m_divisor_sum);
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic wait_drain();
        while (cand_q.size() > 0 || s_valid || sum_q.size() > 0 || hold_req
               || hold_left > 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        @(negedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) cand_q.push_back(rand_candidate());
        wait_drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // edge values, squares, primes, perfect and abundant numbers, full range
        cand_q.push_back(31'd0);   cand_q.push_back(31'd1);   cand_q.push_back(31'd2);
        cand_q.push_back(31'd3);   cand_q.push_back(31'd4);   cand_q.push_back(31'd6);
        cand_q.push_back(31'd9);   cand_q.push_back(31'd12);  cand_q.push_back(31'd16);
        cand_q.push_back(31'd28);  cand_q.push_back(31'd496); cand_q.push_back(31'd945);
        cand_q.push_back(31'd8128);
        cand_q.push_back(31'd8191);
        cand_q.push_back(31'd33550336);
        cand_q.push_back(31'h7fffffff);
        wait_drain();

        run_phase(0, 0, 24);
        run_phase(64, 0, 24);
        run_phase(0, 64, 24);
        run_phase(34, 34, 24);

        // receiver holds off while small candidates keep coming
        @(negedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        repeat (6) cand_q.push_back(VALUE_BITS'($urandom_range(200, 2)));
        wait_drain();

        repeat (100) @(negedge aclk);
        $display("covered %0d words (largest %0d), %0d results, %0d perfect, %0d held cycles",
                 words_sent, largest_sent, results_seen, perfect_seen, held_cycles);
        if (errors == 0 && sum_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout with %0d results outstanding", sum_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
